### hw/rtl/midi_transport_tick_sequencer_top_macros.svh
// Assertion macros for the transport sequencer checker.
// Both sample on clk_i and are quiet while rst_ni is low.
`ifndef MIDI_TRANSPORT_TICK_SEQUENCER_TOP_MACROS_SVH
`define MIDI_TRANSPORT_TICK_SEQUENCER_TOP_MACROS_SVH

// General property.
`define MTTS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mtts assertion failed");

// Condition that must hold on every valid result beat.
`define MTTS_ASSERT_OUT(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    m_axis_tvalid |-> (cond)) else $error("mtts result check failed");

`endif

### hw/rtl/mtts_pkg.sv
package mtts_pkg;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 40;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgClockMode = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgIntRate   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgSrcRate   = 2'd2;

  localparam logic [31:0] StartDelay   = 32'd8000000;
  localparam logic [31:0] TickLenReset = 32'd500000;
  localparam logic [15:0] RateReset    = 16'd96;
  // result buffer holds 16 entries; tick limit is 16
  localparam logic [4:0]  TickLimit    = 5'd16;
  localparam logic [4:0]  CreditLastStep = 5'd16;

  typedef enum logic [2:0] {
    ActElapsed  = 3'd0,
    ActStart    = 3'd1,
    ActStop     = 3'd2,
    ActExtStart = 3'd3,
    ActExtTick  = 3'd4,
    ActExtStop  = 3'd5,
    ActTempo    = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    PhStartWait = 3'd0,
    PhStart     = 3'd1,
    PhFirst     = 3'd2,
    PhNext      = 3'd3,
    PhStop      = 3'd4
  } phase_e;

  typedef enum logic [2:0] {
    EvNone     = 3'd0,
    EvStarted  = 3'd1,
    EvFirst    = 3'd2,
    EvNext     = 3'd3,
    EvDevStop  = 3'd4,
    EvSongStop = 3'd5,
    EvBad      = 3'd6
  } event_e;

  typedef enum logic [3:0] {
    CmdNop,
    CmdElapsed,
    CmdStartInt,
    CmdStartExt,
    CmdStop,
    CmdExtStart,
    CmdExtTick,
    CmdExtStop,
    CmdTempo
  } cmd_e;

  typedef enum logic [3:0] {
    BkIdle,
    BkSongStop,
    BkStartChk,
    BkBound,
    BkPulse,
    BkMod,
    BkModEnd,
    BkDone,
    BkDrain
  } bk_state_e;

  typedef struct packed {
    cmd_e        op;
    logic [31:0] amount;
    logic        manual;
  } cmd_t;

  typedef struct packed {
    logic        clock_mode;
    logic [15:0] int_rate;
    logic [15:0] src_rate;
  } cfg_t;

  typedef struct packed {
    event_e      ev;
    logic [31:0] tnum;
    phase_e      ph;
  } res_t;

  function automatic logic is_running(phase_e ph);
    return (ph == PhStart) || (ph == PhFirst) || (ph == PhNext);
  endfunction

endpackage

### hw/rtl/mtts_front.sv
module mtts_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          clock_mode_i,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [2:0]                    s_action_i,
  input  logic [31:0]                   s_amount_i,
  input  logic                          s_manual_i,
  output logic                          cmd_valid_o,
  input  logic                          cmd_ready_i,
  output mtts_pkg::cmd_t                cmd_o
);
  import mtts_pkg::*;

  cmd_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       dec;
  logic       push, pop;

  // classify the action; external actions only count in external mode
  always_comb begin
    dec.amount = s_amount_i;
    dec.manual = s_manual_i;
    case (action_e'(s_action_i))
      ActElapsed:  dec.op = clock_mode_i ? CmdNop : CmdElapsed;
      ActStart:    dec.op = clock_mode_i ? CmdStartExt : CmdStartInt;
      ActStop:     dec.op = CmdStop;
      ActExtStart: dec.op = clock_mode_i ? CmdExtStart : CmdNop;
      ActExtTick:  dec.op = clock_mode_i ? CmdExtTick : CmdNop;
      ActExtStop:  dec.op = clock_mode_i ? CmdExtStop : CmdNop;
      ActTempo:    dec.op = CmdTempo;
      default:     dec.op = CmdNop;
    endcase
  end

  assign s_ready_o   = (cnt_q != 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = ent_q[rp_q];
  assign push        = s_valid_i && s_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wp_q <= ~wp_q;
      end
      if (pop) begin
        rp_q <= ~rp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= dec;
    end
  end

endmodule

### hw/rtl/mtts_back.sv
module mtts_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  mtts_pkg::cfg_t                 cfg_i,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  mtts_pkg::cmd_t                 cmd_i,
  output logic                           m_valid_o,
  input  logic                           m_ready_i,
  output mtts_pkg::res_t                 m_res_o,
  output logic                           m_over_o,
  output logic                           m_last_o
);
  import mtts_pkg::*;

  bk_state_e   state_q, state_d;
  phase_e      phase_q, phase_d, req_q, req_d;
  logic [31:0] pos_q, pos_d, next_q, next_d, tlen_q, tlen_d, tcnt_q, tcnt_d;
  logic [16:0] credit_q, credit_d, rem_q, rem_d, div_q, div_d;
  logic [4:0]  step_q, step_d, cnt_q, cnt_d;
  logic        manual_q, manual_d, over_q, over_d;
  logic [3:0]  rd_q, rd_d;

  res_t        rbuf_q [16];
  logic        wr_en;
  res_t        wr_data;

  logic        out_valid_q;
  res_t        out_res_q;
  logic        out_over_q, out_last_q;

  logic        load, last_sel;

  // one tick from the current phase
  logic        tk_valid;
  phase_e      tk_phase;
  logic [31:0] tk_cnt;
  event_e      tk_ev;

  logic [32:0]        sum_el;
  logic [31:0]        pos_sat;
  logic signed [34:0] tempo_v;
  logic [31:0]        tempo_clamp;
  logic [16:0]        rem_try;
  logic [16:0]        rate17;

  always_comb begin
    tk_valid = 1'b1;
    tk_phase = PhNext;
    tk_cnt   = tcnt_q + 32'd1;
    tk_ev    = EvNext;
    case (phase_q)
      PhFirst, PhNext: begin
        tk_phase = PhNext;
      end
      PhStart: begin
        tk_phase = PhFirst;
        tk_cnt   = 32'd0;
        tk_ev    = EvFirst;
      end
      default: begin
        tk_valid = 1'b0;
        tk_phase = phase_q;
        tk_cnt   = tcnt_q;
      end
    endcase
  end

  assign sum_el  = {1'b0, pos_q} + {1'b0, cmd_i.amount};
  assign pos_sat = sum_el[32] ? 32'hFFFF_FFFF : sum_el[31:0];

  assign tempo_v = $signed({3'b000, next_q}) + $signed({3'b000, cmd_i.amount})
                 - $signed({3'b000, tlen_q});
  always_comb begin
    if (tempo_v[34]) begin
      tempo_clamp = 32'd0;
    end else if (tempo_v[33:32] != 2'b00) begin
      tempo_clamp = 32'hFFFF_FFFF;
    end else begin
      tempo_clamp = tempo_v[31:0];
    end
  end

  assign rate17  = {1'b0, cfg_i.src_rate};
  // restoring remainder, one dividend bit per cycle
  assign rem_try = {rem_q[15:0], div_q[16]};

  assign cmd_ready_o = (state_q == BkIdle);
  assign load        = (state_q == BkDrain) && (!out_valid_q || m_ready_i);
  assign last_sel    = ({1'b0, rd_q} == (cnt_q - 5'd1));

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    req_d    = req_q;
    pos_d    = pos_q;
    next_d   = next_q;
    tlen_d   = tlen_q;
    tcnt_d   = tcnt_q;
    credit_d = credit_q;
    rem_d    = rem_q;
    div_d    = div_q;
    step_d   = step_q;
    manual_d = manual_q;
    over_d   = over_q;
    cnt_d    = cnt_q;
    rd_d     = rd_q;
    wr_en    = 1'b0;
    wr_data  = '{ev: EvNone, tnum: tcnt_q, ph: phase_q};

    case (state_q)
      BkIdle: begin
        if (cmd_valid_i) begin
          state_d = BkDone;
          case (cmd_i.op)
            CmdElapsed: begin
              case (phase_q)
                PhStartWait: begin
                  if (!manual_q) begin
                    wr_en   = 1'b1;
                    wr_data = '{ev: EvBad, tnum: tcnt_q, ph: phase_q};
                  end
                end
                PhStart: begin
                  pos_d   = pos_sat;
                  state_d = BkStartChk;
                end
                PhFirst, PhNext: begin
                  pos_d   = pos_sat;
                  state_d = BkBound;
                end
                default: ;
              endcase
            end
            CmdStartInt, CmdStartExt: begin
              if (phase_q != PhStop) begin
                wr_en   = 1'b1;
                wr_data = '{ev: EvBad, tnum: tcnt_q, ph: phase_q};
              end else begin
                manual_d = cmd_i.manual;
                req_d    = PhStartWait;
                pos_d    = 32'd0;
                if (cmd_i.op == CmdStartInt) begin
                  next_d  = StartDelay;
                  phase_d = PhStart;
                  wr_en   = 1'b1;
                  wr_data = '{ev: EvStarted, tnum: tcnt_q, ph: PhStart};
                end else begin
                  next_d  = tlen_q;
                  phase_d = PhStartWait;
                end
              end
            end
            CmdStop: begin
              req_d = PhStop;
              if (phase_q != PhStop) begin
                state_d = BkSongStop;
                if (is_running(phase_q)) begin
                  wr_en   = 1'b1;
                  wr_data = '{ev: EvDevStop, tnum: tcnt_q, ph: phase_q};
                end
              end
            end
            CmdExtStop: begin
              state_d = BkSongStop;
              if (is_running(phase_q)) begin
                wr_en   = 1'b1;
                wr_data = '{ev: EvDevStop, tnum: tcnt_q, ph: phase_q};
              end
            end
            CmdExtStart: begin
              if (phase_q == PhStartWait) begin
                pos_d   = 32'd0;
                next_d  = tlen_q;
                phase_d = PhStart;
                wr_en   = 1'b1;
                wr_data = '{ev: EvStarted, tnum: tcnt_q, ph: PhStart};
              end
            end
            CmdExtTick: begin
              if (is_running(phase_q)) begin
                state_d = BkPulse;
              end else if (cfg_i.src_rate != 16'd0) begin
                rem_d   = 17'd0;
                div_d   = credit_q;
                step_d  = 5'd0;
                state_d = BkMod;
              end
            end
            CmdTempo: begin
              if ((phase_q == PhFirst) || (phase_q == PhNext)) begin
                next_d = tempo_clamp;
              end
              tlen_d = cmd_i.amount;
            end
            default: ;
          endcase
        end
      end

      BkSongStop: begin
        phase_d = req_q;
        wr_en   = 1'b1;
        wr_data = '{ev: EvSongStop, tnum: tcnt_q, ph: req_q};
        state_d = BkDone;
      end

      BkStartChk: begin
        state_d = BkDone;
        if (pos_q >= next_q) begin
          pos_d   = 32'd0;
          next_d  = 32'd0;
          state_d = BkBound;
        end
      end

      BkBound: begin
        if (pos_q < next_q) begin
          state_d = BkDone;
        end else if (cnt_q >= TickLimit) begin
          over_d  = 1'b1;
          state_d = BkDone;
        end else begin
          pos_d  = pos_q - next_q;
          next_d = tlen_q;
          if (manual_q && (phase_q == PhStart)) begin
            // manual start: hold at the boundary without a tick
            pos_d   = 32'd0;
            state_d = BkDone;
          end else begin
            if (phase_q == PhStart) begin
              pos_d = 32'd0;
            end
            phase_d = tk_phase;
            tcnt_d  = tk_cnt;
            wr_en   = tk_valid;
            wr_data = '{ev: tk_ev, tnum: tk_cnt, ph: tk_phase};
            cnt_d   = tk_valid ? cnt_q + 5'd1 : cnt_q;
          end
        end
      end

      BkPulse: begin
        if (credit_q < rate17) begin
          credit_d = credit_q + {1'b0, cfg_i.int_rate};
          state_d  = BkDone;
        end else if (cnt_q >= TickLimit) begin
          over_d  = 1'b1;
          state_d = BkDone;
        end else begin
          if (phase_q == PhStart) begin
            pos_d  = 32'd0;
            next_d = tlen_q;
          end
          phase_d  = tk_phase;
          tcnt_d   = tk_cnt;
          wr_en    = tk_valid;
          wr_data  = '{ev: tk_ev, tnum: tk_cnt, ph: tk_phase};
          cnt_d    = tk_valid ? cnt_q + 5'd1 : cnt_q;
          credit_d = credit_q - rate17;
        end
      end

      BkMod: begin
        rem_d  = (rem_try >= rate17) ? rem_try - rate17 : rem_try;
        div_d  = {div_q[15:0], 1'b0};
        step_d = step_q + 5'd1;
        if (step_q == CreditLastStep) begin
          state_d = BkModEnd;
        end
      end

      BkModEnd: begin
        credit_d = rem_q + {1'b0, cfg_i.int_rate};
        state_d  = BkDone;
      end

      BkDone: begin
        if (cnt_q == 5'd0) begin
          wr_en = 1'b1;
          cnt_d = 5'd1;
        end
        rd_d    = 4'd0;
        state_d = BkDrain;
      end

      BkDrain: begin
        if (load) begin
          rd_d = rd_q + 4'd1;
          if (last_sel) begin
            state_d = BkIdle;
            cnt_d   = 5'd0;
            over_d  = 1'b0;
            rd_d    = 4'd0;
          end
        end
      end

      default: state_d = BkIdle;
    endcase

    // every emit outside the tick paths and the closing state counts once here
    if (wr_en && (state_q != BkBound) && (state_q != BkPulse) && (state_q != BkDone)) begin
      cnt_d = cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      phase_q     <= PhStop;
      req_q       <= PhStop;
      pos_q       <= 32'd0;
      next_q      <= 32'd0;
      tlen_q      <= TickLenReset;
      tcnt_q      <= 32'd0;
      credit_q    <= {1'b0, RateReset};
      manual_q    <= 1'b1;
      over_q      <= 1'b0;
      cnt_q       <= 5'd0;
      rd_q        <= 4'd0;
      step_q      <= 5'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      req_q    <= req_d;
      pos_q    <= pos_d;
      next_q   <= next_d;
      tlen_q   <= tlen_d;
      tcnt_q   <= tcnt_d;
      credit_q <= credit_d;
      manual_q <= manual_d;
      over_q   <= over_d;
      cnt_q    <= cnt_d;
      rd_q     <= rd_d;
      step_q   <= step_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    if (wr_en) begin
      rbuf_q[cnt_q[3:0]] <= wr_data;
    end
    if (load) begin
      out_res_q  <= rbuf_q[rd_q];
      out_last_q <= last_sel;
      out_over_q <= over_q;
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_res_o   = out_res_q;
  assign m_over_o  = out_over_q;
  assign m_last_o  = out_last_q;

endmodule

### hw/rtl/midi_transport_tick_sequencer_top.sv
// Transport clock of a sequencer: an input item (kind in tuser) is decoded by the
// front end into a two-entry command queue; the back end runs the phase machine and
// buffers up to 16 results, then streams them out with tlast on the final one and
// the overrun flag on all of them. The back end takes a command in its idle state,
// steps through each tick boundary or clock-credit step (at most 16 ticks plus one
// final check), then passes a closing state and delivers one result per cycle while
// the output is not stalled. An external clock pulse outside a running phase reduces
// the clock credit modulo the source rate one bit a cycle. Results wait in an output
// register, so the next command is taken while the last result is held.
module midi_transport_tick_sequencer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [mtts_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [mtts_pkg::CfgDataW-1:0]     cfg_wdata_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] amount, [32] manual_start, rest zero
  input  logic [mtts_pkg::InDataW-1:0]      s_axis_tdata,
  // [2:0] action
  input  logic [2:0]                        s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] tick_number, [34:32] phase_now, [35] overrun, rest zero
  output logic [mtts_pkg::OutDataW-1:0]     m_axis_tdata,
  // [2:0] event_res
  output logic [2:0]                        m_axis_tuser,
  output logic                              m_axis_tlast
);
  import mtts_pkg::*;

  cfg_t cfg_q;
  logic cmd_valid, cmd_ready;
  cmd_t cmd;
  res_t res;
  logic res_over;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{clock_mode: 1'b0, int_rate: RateReset, src_rate: RateReset};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgClockMode: cfg_q.clock_mode <= cfg_wdata_i[0];
        CfgIntRate:   cfg_q.int_rate   <= cfg_wdata_i;
        CfgSrcRate:   cfg_q.src_rate   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  mtts_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clock_mode_i (cfg_q.clock_mode),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_action_i   (s_axis_tuser),
    .s_amount_i   (s_axis_tdata[31:0]),
    .s_manual_i   (s_axis_tdata[32]),
    .cmd_valid_o  (cmd_valid),
    .cmd_ready_i  (cmd_ready),
    .cmd_o        (cmd)
  );

  mtts_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_res_o     (res),
    .m_over_o    (res_over),
    .m_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'b0000, res_over, res.ph, res.tnum};
  assign m_axis_tuser = res.ev;

endmodule

### hw/rtl/mtts_chk.sv
`include "midi_transport_tick_sequencer_top_macros.svh"

module mtts_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [mtts_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [2:0]                    m_axis_tuser,
  input logic                          m_axis_tlast
);
  import mtts_pkg::*;

  logic                  out_stall;
  logic [OutDataW+3:0]   out_beat;
  logic [2:0]            out_ph;
  logic                  out_parked;

  assign out_stall  = m_axis_tvalid && !m_axis_tready;
  assign out_beat   = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
  assign out_ph     = m_axis_tdata[34:32];
  assign out_parked = (out_ph == PhStop) || (out_ph == PhStartWait);

  // a stalled result beat holds
  `MTTS_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid && $stable(out_beat))
  // first tick restarts the count
  `MTTS_ASSERT_OUT(a_first_zero, (m_axis_tuser != EvFirst) || (m_axis_tdata[31:0] == 32'd0))
  // devices stopped is never the last result of an item, since song stopped follows it
  `MTTS_ASSERT_OUT(a_devstop_not_last, (m_axis_tuser != EvDevStop) || !m_axis_tlast)
  // song stop leaves the transport stopped or waiting for start
  `MTTS_ASSERT_OUT(a_songstop_phase, (m_axis_tuser != EvSongStop) || out_parked)
  // a start always lands in the start phase
  `MTTS_ASSERT_OUT(a_started_phase, (m_axis_tuser != EvStarted) || (out_ph == PhStart))

endmodule

bind midi_transport_tick_sequencer_top mtts_chk u_mtts_chk (.*);
